// ----- src/pdr_pkg.sv -----
// ----------------------------------------------------------------------------
// pdr_pkg: shared types and constants
// Field widths, register indexes, the item and state structs and the output
// saturation helper used by the PD drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdr_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned GP_W    = 16;
  localparam int unsigned GD_W    = 17;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned VEL_W   = 16;
  localparam int unsigned ERR_W   = 26;
  localparam int unsigned CNT_W   = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [CNT_W-1:0]   SETTLE_TICKS = 4'd10;
  localparam logic [CNT_W-1:0]   CNT_MAX      = 4'd15;
  localparam logic signed [16:0] FAST_SPEED   = 17'sd10240;  // 40 % in Q8
  localparam logic signed [16:0] MIN_PUSH     = 17'sd512;    // 2 % in Q8
  localparam logic signed [26:0] VEL_LIMIT    = 27'sd25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_POS  = 3'd0,
    REG_MAX_SPEED   = 3'd1,
    REG_GAIN_P      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_START_SPEED = 3'd4,
    REG_TOLERANCE   = 3'd5,
    REG_HEADING_REF = 3'd6,
    REG_AXIS_MODE   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] target_pos;
    logic [SPEED_W-1:0]      max_speed;
    logic [GP_W-1:0]         gain_p;
    logic [GD_W-1:0]         gain_d;
    logic [SPEED_W-1:0]      start_speed;
    logic [TOL_W-1:0]        tolerance;
    logic signed [POS_W-1:0] heading_ref;
    logic                    axis_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] encoder_pos;
    logic signed [POS_W-1:0] heading;
    logic                    limit_pressed;
    logic                    move_start;
  } in_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] front_left_vel;
    logic signed [VEL_W-1:0] front_right_vel;
    logic signed [VEL_W-1:0] back_left_vel;
    logic signed [VEL_W-1:0] back_right_vel;
    logic                    done_res;
  } res_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] prev_error;
    logic [CNT_W-1:0]        settle_count;
  } st_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [26:0] v);
    logic signed [26:0] r;
    begin
      if (v > VEL_LIMIT) begin
        r = VEL_LIMIT;
      end else if (v < -VEL_LIMIT) begin
        r = -VEL_LIMIT;
      end else begin
        r = v;
      end
      return r[VEL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/pdr_cfg.sv -----
// ----------------------------------------------------------------------------
// pdr_cfg: configuration register file
// Write-only registers, one per index, loaded with their defaults at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pdr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pdr_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_pos  <= '0;
      cfg.max_speed   <= 7'd100;
      cfg.gain_p      <= 16'd10158;
      cfg.gain_d      <= 17'd37683;
      cfg.start_speed <= 7'd20;
      cfg.tolerance   <= 16'd5333;
      cfg.heading_ref <= '0;
      cfg.axis_mode   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (pdr_pkg::cfg_idx_e'(cfg_index))
        pdr_pkg::REG_TARGET_POS:  cfg.target_pos  <= cfg_data;
        pdr_pkg::REG_MAX_SPEED:   cfg.max_speed   <= cfg_data[pdr_pkg::SPEED_W-1:0];
        pdr_pkg::REG_GAIN_P:      cfg.gain_p      <= cfg_data[pdr_pkg::GP_W-1:0];
        pdr_pkg::REG_GAIN_D:      cfg.gain_d      <= cfg_data[pdr_pkg::GD_W-1:0];
        pdr_pkg::REG_START_SPEED: cfg.start_speed <= cfg_data[pdr_pkg::SPEED_W-1:0];
        pdr_pkg::REG_TOLERANCE:   cfg.tolerance   <= cfg_data[pdr_pkg::TOL_W-1:0];
        pdr_pkg::REG_HEADING_REF: cfg.heading_ref <= cfg_data;
        pdr_pkg::REG_AXIS_MODE:   cfg.axis_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/pdr_calc.sv -----
// ----------------------------------------------------------------------------
// pdr_calc: PD speed, ramp cap and wheel mixing
// Combinational datapath for one tick: error, PD sum, ramp cap, heading
// correction, mecanum mix, settle counting and stop conditions.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_calc (
  input  wire pdr_pkg::cfg_t cfg,
  input  wire pdr_pkg::in_t  item,
  input  wire pdr_pkg::st_t  st,
  output pdr_pkg::res_t      res,
  output pdr_pkg::st_t       st_next
);

  logic signed [25:0] prev_eff;
  logic [3:0]         cnt_eff;
  logic signed [24:0] err;
  logic signed [26:0] diff;
  logic signed [41:0] p_term;
  logic signed [44:0] d_term;
  logic signed [45:0] pd;
  logic [45:0]        pd_abs;
  logic [23:0]        aenc;
  logic [39:0]        ramp_prod;
  logic [16:0]        ramp;
  logic [6:0]         cap;
  logic               over;
  logic signed [16:0] cap_q8;
  logic signed [45:0] pd_rnd;
  logic signed [45:0] pd_sh;
  logic signed [16:0] push;
  logic signed [16:0] speed;
  logic               fast;
  logic signed [24:0] corr;
  logic signed [25:0] corr2;
  logic signed [26:0] speed_x;
  logic signed [26:0] corr_x;
  logic signed [15:0] pos_v;
  logic signed [15:0] neg_v;
  logic signed [25:0] err_x;
  logic signed [25:0] tol_x;
  logic               in_band;
  logic [3:0]         cnt_upd;
  logic               settled;
  logic               limit_stop;

  always_comb begin
    // a move start wipes the history before this tick uses it
    prev_eff = item.move_start ? '0 : st.prev_error;
    cnt_eff  = item.move_start ? '0 : st.settle_count;

    err    = {cfg.target_pos[23], cfg.target_pos} + {item.encoder_pos[23], item.encoder_pos};
    diff   = {{2{err[24]}}, err} - {prev_eff[25], prev_eff};
    p_term = err * $signed({1'b0, cfg.gain_p});
    d_term = diff * $signed({1'b0, cfg.gain_d});
    pd     = {{4{p_term[41]}}, p_term} + {d_term[44], d_term};
    pd_abs = pd[45] ? 46'(-pd) : 46'(pd);

    // ramp cap in whole percent
    aenc      = item.encoder_pos[23] ? (~item.encoder_pos + 24'd1) : item.encoder_pos;
    ramp_prod = aenc * cfg.gain_p;
    ramp      = {1'b0, ramp_prod[39:24]} + {10'd0, cfg.start_speed};
    cap       = (ramp > {10'd0, cfg.max_speed}) ? cfg.max_speed : ramp[6:0];

    over   = pd_abs > {15'd0, cap, 24'd0};
    cap_q8 = {2'b00, cap, 8'd0};
    push   = cfg.target_pos[23] ? -pdr_pkg::MIN_PUSH : pdr_pkg::MIN_PUSH;
    pd_rnd = pd + 46'sd32768;
    pd_sh  = pd_rnd >>> 16;
    if (over) begin
      speed = cfg.target_pos[23] ? -cap_q8 : cap_q8;
    end else begin
      speed = pd_sh[16:0] + push;
    end

    fast  = (speed >= pdr_pkg::FAST_SPEED) || (speed <= -pdr_pkg::FAST_SPEED);
    corr  = {item.heading[23], item.heading} - {cfg.heading_ref[23], cfg.heading_ref};
    corr2 = fast ? {corr, 1'b0} : {corr[24], corr};

    speed_x = {{10{speed[16]}}, speed};
    corr_x  = {corr2[25], corr2};
    pos_v   = pdr_pkg::sat_vel(speed_x - corr_x);
    neg_v   = pdr_pkg::sat_vel(-speed_x - corr_x);

    err_x   = {err[24], err};
    tol_x   = {10'd0, cfg.tolerance};
    in_band = (err_x < tol_x) && (err_x > -tol_x);
    if (!in_band) begin
      cnt_upd = '0;
    end else if (cnt_eff == pdr_pkg::CNT_MAX) begin
      cnt_upd = pdr_pkg::CNT_MAX;
    end else begin
      cnt_upd = cnt_eff + 4'd1;
    end
    settled = cnt_upd > pdr_pkg::SETTLE_TICKS;

    // limit switch only stops a forward move in the forward/back pattern
    limit_stop = !cfg.axis_mode && item.limit_pressed && !cfg.target_pos[23]
                 && (cfg.target_pos != '0);

    if (limit_stop) begin
      st_next.prev_error   = prev_eff;
      st_next.settle_count = cnt_eff;
    end else begin
      st_next.prev_error   = err_x;
      st_next.settle_count = cnt_upd;
    end

    if (limit_stop || settled) begin
      res.front_left_vel  = '0;
      res.front_right_vel = '0;
      res.back_left_vel   = '0;
      res.back_right_vel  = '0;
      res.done_res        = 1'b1;
    end else if (!cfg.axis_mode) begin
      res.front_left_vel  = pos_v;
      res.front_right_vel = neg_v;
      res.back_left_vel   = pos_v;
      res.back_right_vel  = neg_v;
      res.done_res        = 1'b0;
    end else begin
      res.front_left_vel  = pos_v;
      res.front_right_vel = pos_v;
      res.back_left_vel   = neg_v;
      res.back_right_vel  = neg_v;
      res.done_res        = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- src/pd_drive_with_ramp_cap.sv -----
// ----------------------------------------------------------------------------
// pd_drive_with_ramp_cap: PD drive controller with acceleration ramp cap
// One sensor sample in, four mecanum wheel velocities and a done flag out.
// ----------------------------------------------------------------------------
// Pipeline: a sample passes the input register, then the result register.
// Throughput: one sample per cycle while the result sink is ready; the tick
//   history updates in the same cycle as the single-pass datapath, so
//   consecutive samples never wait on it.
// Reset: configuration returns to its defaults, previous error and settle
//   count clear to zero, both pipeline registers empty.
`default_nettype none

module pd_drive_with_ramp_cap (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // encoder_pos[23:0], heading[47:24], limit_pressed[48], move_start[49], zero pad
  input  wire logic [pdr_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // front_left_vel[15:0], front_right_vel[31:16], back_left_vel[47:32],
  // back_right_vel[63:48], done_res[64], zero pad
  output logic [pdr_pkg::OUT_TDATA_W-1:0]         m_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic [pdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pdr_pkg::cfg_t cfg;
  pdr_pkg::in_t  s1;
  logic          s1_v;
  pdr_pkg::res_t res;
  pdr_pkg::res_t o_data;
  logic          o_v;
  pdr_pkg::st_t  st;
  pdr_pkg::st_t  st_next;
  logic          adv;

  pdr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdr_calc u_calc (
    .cfg     (cfg),
    .item    (s1),
    .st      (st),
    .res     (res),
    .st_next (st_next)
  );

  // input stage moves on whenever the result register is free or draining
  assign adv      = s1_v && (!o_v || m_tready);
  assign s_tready = !s1_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      o_v  <= 1'b0;
      st   <= '0;
    end else begin
      if (s_tready) begin
        s1_v <= s_tvalid;
      end
      if (adv) begin
        o_v <= 1'b1;
        st  <= st_next;
      end else if (m_tready) begin
        o_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1.encoder_pos   <= s_tdata[23:0];
      s1.heading       <= s_tdata[47:24];
      s1.limit_pressed <= s_tdata[48];
      s1.move_start    <= s_tdata[49];
    end
    if (adv) begin
      o_data <= res;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {7'd0, o_data.done_res, o_data.back_right_vel, o_data.back_left_vel,
                     o_data.front_right_vel, o_data.front_left_vel};

`ifndef SYNTHESIS
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (o_v && o_data.done_res) |-> (o_data.front_left_vel == '0 &&
      o_data.front_right_vel == '0 && o_data.back_left_vel == '0 &&
      o_data.back_right_vel == '0))
    else $error("done transfer with non-zero wheel velocity");

  a_vel_range: assert property (@(posedge clk) disable iff (rst)
    o_v |-> (o_data.front_left_vel <= 16'sd25600 && o_data.front_left_vel >= -16'sd25600 &&
             o_data.back_right_vel <= 16'sd25600 && o_data.back_right_vel >= -16'sd25600))
    else $error("wheel velocity outside saturation range");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_v && o_v && !m_tready) |-> !s_tready)
    else $error("sample taken while both stages full and stalled");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !adv) |=> ($stable(st.prev_error) && $stable(st.settle_count)))
    else $error("tick history changed without a sample advancing");
`endif

endmodule

`default_nettype wire

// ----- test/pd_drive_with_ramp_cap_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pd_drive_with_ramp_cap_chk: scoreboard for the PD drive controller
// Tracks register writes, works out the wheel command for every sample
// transfer and compares each result transfer with the oldest command waiting.
// ----------------------------------------------------------------------------

package pdr_tb_pkg;

  localparam logic AXIS_FORWARD = 1'b0;
  localparam logic AXIS_STRAFE  = 1'b1;

endpackage

module pd_drive_with_ramp_cap_chk (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // encoder_pos[23:0], heading[47:24], limit_pressed[48], move_start[49], zero pad
  input  logic [pdr_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // front_left_vel[15:0], front_right_vel[31:16], back_left_vel[47:32],
  // back_right_vel[63:48], done_res[64], zero pad
  input  logic [pdr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_wr_en,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_seen,
  output int                                 done_seen
);

  localparam longint WHEEL_MAX    = 25600;
  localparam longint FAST_Q8      = 40 * 256;
  localparam longint PUSH_Q8      = 512;
  localparam longint ROUND_HALF   = 32768;
  localparam int     SETTLE_LIMIT = 10;
  localparam int     COUNT_TOP    = 15;

  pdr_pkg::cfg_t regs;
  longint        last_err;
  int            settle_ticks;
  pdr_pkg::res_t wheel_cmd_q[$];

  function automatic longint clip_wheel(longint v);
    if (v > WHEEL_MAX) return WHEEL_MAX;
    if (v < -WHEEL_MAX) return -WHEEL_MAX;
    return v;
  endfunction

  // one control tick: updates the tick history and returns the wheel command
  task automatic drive_tick(input pdr_pkg::in_t smp, output pdr_pkg::res_t cmd);
    longint enc, head, tgt, href, tol, err, pd, aenc, apd, cap, dir, speed;
    longint corr, pos, neg;
    begin
      enc  = $signed(smp.encoder_pos);
      head = $signed(smp.heading);
      tgt  = $signed(regs.target_pos);
      href = $signed(regs.heading_ref);
      tol  = regs.tolerance;
      cmd  = '0;
      if (smp.move_start) begin
        last_err     = 0;
        settle_ticks = 0;
      end
      if (regs.axis_mode == pdr_tb_pkg::AXIS_FORWARD && smp.limit_pressed && tgt > 0) begin
        // limit stop: history left untouched
        cmd.done_res = 1'b1;
      end else begin
        err  = tgt + enc;
        pd   = err * longint'(regs.gain_p) + (err - last_err) * longint'(regs.gain_d);
        aenc = (enc < 0) ? -enc : enc;
        cap  = ((aenc * longint'(regs.gain_p)) >>> 24) + longint'(regs.start_speed);
        if (cap > longint'(regs.max_speed)) cap = regs.max_speed;
        dir = (tgt >= 0) ? 1 : -1;
        apd = (pd < 0) ? -pd : pd;
        if (apd > (cap <<< 24)) speed = dir * (cap <<< 8);
        else speed = ((pd + ROUND_HALF) >>> 16) + dir * PUSH_Q8;
        corr = head - href;
        if (((speed < 0) ? -speed : speed) >= FAST_Q8) corr = corr * 2;
        pos = clip_wheel(speed - corr);
        neg = clip_wheel(-speed - corr);
        cmd.front_left_vel = pos[15:0];
        if (regs.axis_mode == pdr_tb_pkg::AXIS_STRAFE) begin
          cmd.front_right_vel = pos[15:0];
          cmd.back_left_vel   = neg[15:0];
        end else begin
          cmd.front_right_vel = neg[15:0];
          cmd.back_left_vel   = pos[15:0];
        end
        cmd.back_right_vel = neg[15:0];
        last_err = err;
        if (err < tol && err > -tol) begin
          if (settle_ticks < COUNT_TOP) settle_ticks++;
        end else begin
          settle_ticks = 0;
        end
        if (settle_ticks > SETTLE_LIMIT) begin
          cmd          = '0;
          cmd.done_res = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    pdr_pkg::in_t  smp;
    pdr_pkg::res_t want, got;
    string         bad;
    if (rst) begin
      regs.target_pos  = '0;
      regs.max_speed   = 7'd100;
      regs.gain_p      = 16'd10158;
      regs.gain_d      = 17'd37683;
      regs.start_speed = 7'd20;
      regs.tolerance   = 16'd5333;
      regs.heading_ref = '0;
      regs.axis_mode   = pdr_tb_pkg::AXIS_FORWARD;
      last_err         = 0;
      settle_ticks     = 0;
      wheel_cmd_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          pdr_pkg::REG_TARGET_POS:  regs.target_pos  = cfg_data[23:0];
          pdr_pkg::REG_MAX_SPEED:   regs.max_speed   = cfg_data[6:0];
          pdr_pkg::REG_GAIN_P:      regs.gain_p      = cfg_data[15:0];
          pdr_pkg::REG_GAIN_D:      regs.gain_d      = cfg_data[16:0];
          pdr_pkg::REG_START_SPEED: regs.start_speed = cfg_data[6:0];
          pdr_pkg::REG_TOLERANCE:   regs.tolerance   = cfg_data[15:0];
          pdr_pkg::REG_HEADING_REF: regs.heading_ref = cfg_data[23:0];
          pdr_pkg::REG_AXIS_MODE:   regs.axis_mode   = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        smp.encoder_pos   = s_tdata[23:0];
        smp.heading       = s_tdata[47:24];
        smp.limit_pressed = s_tdata[48];
        smp.move_start    = s_tdata[49];
        drive_tick(smp, want);
        wheel_cmd_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.front_left_vel  = m_tdata[15:0];
        got.front_right_vel = m_tdata[31:16];
        got.back_left_vel   = m_tdata[47:32];
        got.back_right_vel  = m_tdata[63:48];
        got.done_res        = m_tdata[64];
        results_seen++;
        if (got.done_res === 1'b1) done_seen++;
        if (wheel_cmd_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result transfer %0d arrived with no command outstanding",
                     results_seen);
        end else begin
          want = wheel_cmd_q.pop_front();
          bad  = "";
          if (got.front_left_vel !== want.front_left_vel) bad = {bad, " front_left"};
          if (got.front_right_vel !== want.front_right_vel) bad = {bad, " front_right"};
          if (got.back_left_vel !== want.back_left_vel) bad = {bad, " back_left"};
          if (got.back_right_vel !== want.back_right_vel) bad = {bad, " back_right"};
          if (got.done_res !== want.done_res) bad = {bad, " done"};
          if (bad != "") begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d wrong in%s", results_seen, bad);
              $display("  exp FL %0d FR %0d BL %0d BR %0d done %0b",
                       want.front_left_vel, want.front_right_vel,
                       want.back_left_vel, want.back_right_vel, want.done_res);
              $display("  got FL %0d FR %0d BL %0d BR %0d done %0b",
                       got.front_left_vel, got.front_right_vel,
                       got.back_left_vel, got.back_right_vel, got.done_res);
            end
          end
        end
      end
    end
    pending = wheel_cmd_q.size();
  end

endmodule

// ----- test/pd_drive_with_ramp_cap_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pd_drive_with_ramp_cap_tb: regression bench for the PD drive controller
// Directed samples at register extremes, limit stops and a settled move, then
// random moves and noise under several register settings, with bursty sample
// traffic and a stalling result sink. The checker scores every transfer.
// ----------------------------------------------------------------------------

module pd_drive_with_ramp_cap_tb;

  localparam int     RESET_CYCLES  = 12;
  localparam int     CYCLE_LIMIT   = 600000;
  localparam int     RANDOM_PHASES = 10;
  localparam int     PHASE_SAMPLES = 168;
  localparam longint POS_MAX       = 8388607;
  localparam longint POS_MIN       = -8388608;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [pdr_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [pdr_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_wr_en = 1'b0;
  pdr_pkg::cfg_idx_e               cfg_index = pdr_pkg::REG_TARGET_POS;
  logic [pdr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  int fail_count, pending, results_seen, done_seen;
  int cycle_cnt     = 0;
  int samples_sent  = 0;
  int settings_used = 1;
  int burst_left    = 0;
  int stall_mode    = 0;
  int mode_left     = 0;

  pd_drive_with_ramp_cap dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pd_drive_with_ramp_cap_chk u_chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .done_seen    (done_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result sink: always ready, random, periodic or long stalls
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 9) < 7);
      2:       m_tready <= (cycle_cnt % 5) > 1;
      default: m_tready <= ($urandom_range(0, 15) == 0) ? ~m_tready : m_tready;
    endcase
  end

  function automatic logic [23:0] clamp24(longint v);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v[23:0];
  endfunction

  function automatic pdr_pkg::in_t make_sample(longint enc, longint head, logic lim,
                                               logic start);
    pdr_pkg::in_t smp;
    smp.encoder_pos   = clamp24(enc);
    smp.heading       = clamp24(head);
    smp.limit_pressed = lim;
    smp.move_start    = start;
    return smp;
  endfunction

  function automatic pdr_pkg::cfg_t setting(longint tgt, int maxs, int gp, int gd, int ss,
                                            int tol, longint href, logic axis);
    pdr_pkg::cfg_t c;
    c.target_pos  = clamp24(tgt);
    c.max_speed   = 7'(maxs);
    c.gain_p      = 16'(gp);
    c.gain_d      = 17'(gd);
    c.start_speed = 7'(ss);
    c.tolerance   = 16'(tol);
    c.heading_ref = clamp24(href);
    c.axis_mode   = axis;
    return c;
  endfunction

  function automatic pdr_pkg::cfg_t random_setting();
    logic [23:0] r;
    longint      tgt, href;
    int          maxs, gp, gd, tol;
    r = 24'($urandom);
    case ($urandom_range(0, 3))
      0:       tgt = $signed(r);
      1:       tgt = $urandom_range(0, 200000);
      2:       tgt = -longint'($urandom_range(0, 200000));
      default: tgt = ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
    endcase
    if ($urandom_range(0, 3) == 0) maxs = ($urandom_range(0, 1) != 0) ? 100 : 0;
    else maxs = $urandom_range(0, 100);
    gp  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(2000, 20000);
    gd  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 60000);
    tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(500, 8000);
    r = 24'($urandom);
    href = ($urandom_range(0, 2) == 0) ? $signed(r) : longint'($urandom_range(0, 10000)) - 5000;
    return setting(tgt, maxs, gp, gd, $urandom_range(0, 100), tol, href,
                   ($urandom_range(0, 1) != 0) ? pdr_tb_pkg::AXIS_STRAFE
                                               : pdr_tb_pkg::AXIS_FORWARD);
  endfunction

  task automatic write_reg(pdr_pkg::cfg_idx_e idx, logic [pdr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic load_setting(pdr_pkg::cfg_t c);
    write_reg(pdr_pkg::REG_TARGET_POS, c.target_pos);
    write_reg(pdr_pkg::REG_MAX_SPEED, 24'(c.max_speed));
    write_reg(pdr_pkg::REG_GAIN_P, 24'(c.gain_p));
    write_reg(pdr_pkg::REG_GAIN_D, 24'(c.gain_d));
    write_reg(pdr_pkg::REG_START_SPEED, 24'(c.start_speed));
    write_reg(pdr_pkg::REG_TOLERANCE, 24'(c.tolerance));
    write_reg(pdr_pkg::REG_HEADING_REF, c.heading_ref);
    write_reg(pdr_pkg::REG_AXIS_MODE, 24'(c.axis_mode));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // hold off the sender until every outstanding result has been taken
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic send_sample(pdr_pkg::in_t smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, smp.move_start, smp.limit_pressed, smp.heading, smp.encoder_pos};
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // a move: ramp the encoder towards the target, then hold near it
  task automatic run_move(pdr_pkg::cfg_t c);
    longint      tgt, href, jitter, enc, head;
    int          steps, hold;
    logic [23:0] r;
    tgt    = $signed(c.target_pos);
    href   = $signed(c.heading_ref);
    jitter = longint'(c.tolerance) / 2 + 1;
    steps  = $urandom_range(4, 40);
    hold   = $urandom_range(0, 20);
    for (int k = 0; k < steps + hold; k++) begin
      enc = (k < steps) ? -(tgt * k) / steps : -tgt;
      enc = enc + longint'($urandom_range(0, 2 * jitter)) - jitter;
      r   = 24'($urandom);
      head = ($urandom_range(0, 9) == 0) ? $signed(r)
                                         : href + longint'($urandom_range(0, 6000)) - 3000;
      send_sample(make_sample(enc, head, $urandom_range(0, 11) == 0,
                              k == 0 || $urandom_range(0, 59) == 0));
    end
  endtask

  task automatic run_noise(int n);
    logic [63:0] r;
    repeat (n) begin
      r = {$urandom, $urandom};
      send_sample(r[49:0]);
    end
  endtask

  initial begin : stimulus
    pdr_pkg::cfg_t c;
    int            phase_start;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // defaults after reset; limit pressed with zero target must not stop
    send_sample(make_sample(0, 0, 1'b0, 1'b1));
    send_sample(make_sample(POS_MAX, POS_MIN, 1'b0, 1'b0));
    send_sample(make_sample(POS_MIN, POS_MAX, 1'b0, 1'b0));
    send_sample(make_sample(-100, 50, 1'b1, 1'b0));
    drain();

    // top gains, start speed above max speed, forward limit stops
    load_setting(setting(POS_MAX, 50, 65535, 131071, 100, 65535, POS_MIN,
                         pdr_tb_pkg::AXIS_FORWARD));
    send_sample(make_sample(0, 0, 1'b0, 1'b1));
    send_sample(make_sample(-8388607, 0, 1'b1, 1'b0));
    send_sample(make_sample(-8388607, POS_MIN, 1'b1, 1'b1));
    send_sample(make_sample(-8388600, POS_MIN, 1'b0, 1'b0));
    drain();

    // zero gains and speeds, strafe ignores the limit switch
    load_setting(setting(POS_MIN, 0, 0, 0, 0, 0, POS_MAX, pdr_tb_pkg::AXIS_STRAFE));
    send_sample(make_sample(0, POS_MAX, 1'b1, 1'b1));
    send_sample(make_sample(POS_MAX, POS_MIN, 1'b1, 1'b0));
    send_sample(make_sample(-1, 0, 1'b0, 1'b0));
    drain();

    // settle inside the band long enough to finish, then leave it
    load_setting(setting(1000, 100, 10158, 37683, 20, 100, 0, pdr_tb_pkg::AXIS_FORWARD));
    for (int k = 0; k < 12; k++)
      send_sample(make_sample(-1000 + longint'($urandom_range(0, 10)) - 5, 0, 1'b0, k == 0));
    send_sample(make_sample(0, 0, 1'b0, 1'b0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      c = random_setting();
      load_setting(c);
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_SAMPLES) begin
        if ($urandom_range(0, 4) == 0) run_noise($urandom_range(1, 6));
        else run_move(c);
        if ($urandom_range(0, 4) == 0) drain();
      end
    end
    drain();
    repeat (8) @(negedge clk);

    $display("Covered %0d samples under %0d register settings, %0d results checked.",
             samples_sent, settings_used, results_seen);
    $display("%0d results reported a finished move; %0d checks failed.",
             done_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- pd_drive_with_ramp_cap.f -----
src/pdr_pkg.sv
src/pdr_cfg.sv
src/pdr_calc.sv
src/pd_drive_with_ramp_cap.sv
test/pd_drive_with_ramp_cap_chk.sv
test/pd_drive_with_ramp_cap_tb.sv
